/* hdl/npq_pkg.sv */
// Shared constants and types of the nearest palette quantizer.
package npq_pkg;

	localparam int PIXEL_W     = 16;
	localparam int CHAN_W      = 5;
	localparam int IDX_W       = 4;
	localparam int MAX_ENTRIES = 16;
	localparam int ENTRY_W     = 16;
	localparam int REG_W       = 64;
	localparam int REG_COUNT   = 4;
	localparam int ADDR_W      = 5;
	// Largest distance is three channels of 31, so 93 fits in 7 bits.
	localparam int DIST_W      = 7;

	localparam int                 OPAQUE_BIT = 15;
	localparam logic [PIXEL_W-1:0] SKIP_PIXEL = 16'hBA18;

	// Register select, taken from paddr[4:3].
	typedef enum logic [1:0] {
		REG_PAL_0_3   = 2'd0,
		REG_PAL_4_7   = 2'd1,
		REG_PAL_8_11  = 2'd2,
		REG_PAL_12_15 = 2'd3
	} npq_reg_t;

	// What one cell hands to the next.
	typedef struct packed {
		logic [3*CHAN_W-1:0] chans;
		logic                opaque;
		logic                skip;
		logic                last;
		logic [DIST_W-1:0]   best_dist;
		logic [IDX_W-1:0]    idx;
	} npq_item_t;

endpackage

/* hdl/npq_if.sv */
// Stream interfaces for pixels in and palette indexes out.
interface npq_in_if;
	logic                          valid;
	logic                          ready;
	logic [npq_pkg::PIXEL_W-1:0]   pixel;
	logic                          last_pixel;

	modport source (output valid, pixel, last_pixel, input ready);
	modport sink   (input valid, pixel, last_pixel, output ready);
endinterface

interface npq_out_if;
	logic                        valid;
	logic                        ready;
	logic [npq_pkg::IDX_W-1:0]   palette_index;
	logic                        transparent;
	logic                        last_out;

	modport source (output valid, palette_index, transparent, last_out, input ready);
	modport sink   (input valid, palette_index, transparent, last_out, output ready);
endinterface

/* hdl/npq_cfg.sv */
// APB register file holding the sixteen palette entries.
module npq_cfg (
	input  logic                                                 clk,
	input  logic                                                 arst_n,
	input  logic                                                 psel,
	input  logic                                                 penable,
	input  logic                                                 pwrite,
	input  logic [npq_pkg::ADDR_W-1:0]                           paddr,
	input  logic [npq_pkg::REG_W-1:0]                            pwdata,
	output logic [npq_pkg::REG_W-1:0]                            prdata,
	output logic                                                 pready,
	output logic [npq_pkg::MAX_ENTRIES-1:0][npq_pkg::ENTRY_W-1:0] palette
);
	import npq_pkg::*;

	logic [REG_COUNT-1:0][REG_W-1:0] pal_q;
	npq_reg_t                        sel;
	logic                            wr_en;

	assign sel    = npq_reg_t'(paddr[ADDR_W-1:3]);
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pal_q <= '0;
		end else if (wr_en) begin
			unique case (sel)
				REG_PAL_0_3:   pal_q[0] <= pwdata;
				REG_PAL_4_7:   pal_q[1] <= pwdata;
				REG_PAL_8_11:  pal_q[2] <= pwdata;
				REG_PAL_12_15: pal_q[3] <= pwdata;
				default:       pal_q[0] <= pwdata;
			endcase
		end
	end

	always_comb begin
		unique case (sel)
			REG_PAL_0_3:   prdata = pal_q[0];
			REG_PAL_4_7:   prdata = pal_q[1];
			REG_PAL_8_11:  prdata = pal_q[2];
			REG_PAL_12_15: prdata = pal_q[3];
			default:       prdata = pal_q[0];
		endcase
	end

	assign palette = pal_q;

endmodule

/* hdl/npq_cell.sv */
// One compare cell: distance to its own palette entry, keeps the better match.
module npq_cell #(
	parameter int IDX = 0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [npq_pkg::ENTRY_W-1:0] entry,
	input  logic                        up_valid,
	output logic                        up_ready,
	input  npq_pkg::npq_item_t          up_item,
	output logic                        dn_valid,
	input  logic                        dn_ready,
	output npq_pkg::npq_item_t          dn_item
);
	import npq_pkg::*;

	logic      vld_q;
	npq_item_t item_q;
	npq_item_t nxt;
	logic      take;
	logic [CHAN_W-1:0] d0, d1, d2;
	logic [DIST_W-1:0] cand_dist;

	function automatic logic [CHAN_W-1:0] absdiff(input logic [CHAN_W-1:0] a,
	                                              input logic [CHAN_W-1:0] b);
		return (a < b) ? (b - a) : (a - b);
	endfunction

	assign d0 = absdiff(up_item.chans[CHAN_W-1:0], entry[CHAN_W-1:0]);
	assign d1 = absdiff(up_item.chans[2*CHAN_W-1:CHAN_W], entry[2*CHAN_W-1:CHAN_W]);
	assign d2 = up_item.skip ? '0
	          : absdiff(up_item.chans[3*CHAN_W-1:2*CHAN_W], entry[3*CHAN_W-1:2*CHAN_W]);
	assign cand_dist = DIST_W'(d0) + DIST_W'(d1) + DIST_W'(d2);

	always_comb begin
		nxt = up_item;
		// strict compare: the lower index wins a tie
		if (cand_dist < up_item.best_dist) begin
			nxt.best_dist = cand_dist;
			nxt.idx       = IDX_W'(IDX);
		end
	end

	assign take     = ~vld_q | dn_ready;
	assign up_ready = take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (take) begin
			vld_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take & up_valid) begin
			item_q <= nxt;
		end
	end

	assign dn_valid = vld_q;
	assign dn_item  = item_q;

endmodule

/* hdl/nearest_palette_quantizer.sv */
// Top level of the nearest palette quantizer: cell chain, registers, stream ports.
// Maps RGB5551 pixels to the nearest of PALETTE_ENTRIES palette colours by
// Manhattan distance over the three 5-bit channels, lowest index on a tie.
// Takes one pixel per clock while the sink keeps taking results; each result
// passes through the chain of compare cells (one per entry, one register each).
// The last cell's register is the output register, and every cell takes a new
// item whenever it is empty or its neighbour is taking its content, so pixels
// keep entering while a result waits on a stalled sink as long as the chain
// has a free slot. Pixels with bit 15 clear come out transparent with index 0;
// the exact pixel 0xBA18 ignores its bits 14-10 channel. The palette lives in
// four 64-bit APB registers at byte addresses 0, 8, 16 and 24 (entry 4i in
// bits 15-0 of register i); the address bits below bit 3 are ignored. Write
// the palette only while the block is idle.
module nearest_palette_quantizer #(
	parameter int PALETTE_ENTRIES = npq_pkg::MAX_ENTRIES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	npq_in_if.sink                        pix_in,
	npq_out_if.source                     res_out,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [npq_pkg::ADDR_W-1:0]    paddr,
	input  logic [npq_pkg::REG_W-1:0]     pwdata,
	output logic [npq_pkg::REG_W-1:0]     prdata,
	output logic                          pready
);
	import npq_pkg::*;

	localparam int N = PALETTE_ENTRIES;

	logic [MAX_ENTRIES-1:0][ENTRY_W-1:0] palette;

	// link k feeds cell k; link N is the output of the chain
	npq_item_t        item  [N+1];
	logic [N:0]       vld;
	logic [N:0]       rdy;

	npq_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.palette (palette)
	);

	// Entry to the chain: distance starts above any real value, so cell 0
	// always takes its own entry as the first candidate.
	always_comb begin
		item[0].chans     = pix_in.pixel[3*CHAN_W-1:0];
		item[0].opaque    = pix_in.pixel[OPAQUE_BIT];
		item[0].skip      = (pix_in.pixel == SKIP_PIXEL);
		item[0].last      = pix_in.last_pixel;
		item[0].best_dist = '1;
		item[0].idx       = '0;
	end
	assign vld[0]       = pix_in.valid;
	assign pix_in.ready = rdy[0];

	for (genvar k = 0; k < N; k++) begin : g_cell
		npq_cell #(.IDX(k)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.entry    (palette[k]),
			.up_valid (vld[k]),
			.up_ready (rdy[k]),
			.up_item  (item[k]),
			.dn_valid (vld[k+1]),
			.dn_ready (rdy[k+1]),
			.dn_item  (item[k+1])
		);
	end

	// Output side: transparent pixels report index 0 whatever the chain found.
	assign rdy[N]                = res_out.ready;
	assign res_out.valid         = vld[N];
	assign res_out.palette_index = item[N].opaque ? item[N].idx : '0;
	assign res_out.transparent   = ~item[N].opaque;
	assign res_out.last_out      = item[N].last;

	// A transparent result never carries a non-zero index.
	a_transp_idx: assert property (@(posedge clk) disable iff (!arst_n)
		res_out.valid && res_out.transparent |-> res_out.palette_index == '0)
		else $error("transparent result with non-zero index");

	// The winner is always one of the configured entries.
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_out.valid |-> 32'(res_out.palette_index) < N)
		else $error("palette index beyond entry count");

	// Every result, opaque or not, has a real distance, never the start value.
	a_dist_real: assert property (@(posedge clk) disable iff (!arst_n)
		vld[N] |-> item[N].best_dist <= DIST_W'(3 * ((1 << CHAN_W) - 1)))
		else $error("result distance out of range");

	// A pixel transfer lands in the first cell.
	a_first_fill: assert property (@(posedge clk) disable iff (!arst_n)
		pix_in.valid && pix_in.ready |=> vld[1])
		else $error("accepted pixel lost at chain entry");

	// Input is only held off when the first cell is occupied.
	a_stall_why: assert property (@(posedge clk) disable iff (!arst_n)
		!pix_in.ready |-> vld[1] && !rdy[1])
		else $error("input stalled with room in the chain");

endmodule

/* test/nearest_palette_quantizer_test.sv */
// Self-checking testbench of the nearest palette quantizer: stream traffic, palette registers.
module nearest_palette_quantizer_test;
	timeunit 1ns;
	timeprecision 1ps;

	import npq_pkg::*;

	// Cycles with no transfer on any port before the run is declared hung.
	// The slowest legal stretch is a pipeline drain plus a receiver stall run;
	// this leaves a wide margin.
	localparam int STALL_LIMIT = 4000;
	// Settling time after the last result, sized from the number of compare cells.
	localparam int DRAIN_CYCLES = 2 * MAX_ENTRIES + 4;
	localparam int PRINT_CAP = 40;

	// Palette fill patterns used by the random phases.
	typedef enum int {
		PAL_RANDOM,
		PAL_CLUSTERED,
		PAL_SATURATED,
		PAL_DARK
	} palette_style_t;

	// One expected quantizer result.
	typedef struct packed {
		logic [IDX_W-1:0] index;
		logic             transparent;
		logic             last;
	} quant_result_t;

	logic clk = 1'b0;
	logic arst_n;

	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [REG_W-1:0]  pwdata;
	logic [REG_W-1:0]  prdata;
	logic              pready;

	npq_in_if  pix_if();
	npq_out_if res_if();

	// Shadow of the four palette registers, updated on each APB write.
	logic [REG_W-1:0] palette_shadow [REG_COUNT];
	// Results owed by the block, oldest first.
	quant_result_t    pending_results [$];

	int send_idle_pct;
	int recv_stall_pct;
	int pixels_sent;
	int results_checked;
	int palette_writes;
	int mismatch_count;
	int quiet_cycles;

	nearest_palette_quantizer #(
		.PALETTE_ENTRIES(MAX_ENTRIES)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_in  (pix_if),
		.res_out (res_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #1 clk = ~clk;

	// One line per mismatch, up to PRINT_CAP of them; the count decides the verdict.
	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatch_count++;
		if (mismatch_count <= PRINT_CAP) begin
			$display("[%0t] MISMATCH %s: got %0h, expected %0h", $realtime, what, got, want);
		end
	endtask

	function automatic int chan_gap(input logic [CHAN_W-1:0] a, input logic [CHAN_W-1:0] b);
		return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
	endfunction

	// Nearest palette entry by Manhattan distance over the 5-bit channels.
	// Entry bit 15 plays no part; the first entry at the smallest distance wins.
	// The one odd pixel value drops its bits 14-10 channel from the sum.
	function automatic quant_result_t quantize_pixel(input logic [PIXEL_W-1:0] pixel,
			input logic last);
		quant_result_t      r;
		int                 best_dist;
		int                 gap_total;
		logic [ENTRY_W-1:0] entry;
		r.index       = '0;
		r.transparent = 1'b0;
		r.last        = last;
		if (!pixel[OPAQUE_BIT]) begin
			r.transparent = 1'b1;
		end else begin
			best_dist = 1 << 30;
			for (int e = 0; e < MAX_ENTRIES; e++) begin
				entry     = palette_shadow[e / 4][(e % 4) * ENTRY_W +: ENTRY_W];
				gap_total = chan_gap(pixel[4:0], entry[4:0]) +
					chan_gap(pixel[9:5], entry[9:5]);
				if (pixel != SKIP_PIXEL) begin
					gap_total += chan_gap(pixel[14:10], entry[14:10]);
				end
				if (gap_total < best_dist) begin
					best_dist = gap_total;
					r.index   = e[IDX_W-1:0];
				end
			end
		end
		return r;
	endfunction

	// Receiver: ready redrawn every falling edge at the current stall rate.
	always @(negedge clk) begin
		res_if.ready = ($urandom_range(99) >= recv_stall_pct);
	end

	// Monitor at the rising edge: predict on each pixel transfer, check each
	// result transfer against the oldest prediction, and run the watchdog.
	always @(posedge clk) begin
		quant_result_t want;
		if (arst_n) begin
			// Results are popped before this edge's pixel is queued; a pixel
			// never comes out on the edge it goes in.
			if (res_if.valid && res_if.ready) begin
				results_checked++;
				if (pending_results.size() == 0) begin
					report_mismatch("result with none pending",
						64'({res_if.palette_index, res_if.transparent, res_if.last_out}),
						64'(0));
				end else begin
					want = pending_results.pop_front();
					if (res_if.palette_index !== want.index)
						report_mismatch("palette_index", 64'(res_if.palette_index),
							64'(want.index));
					if (res_if.transparent !== want.transparent)
						report_mismatch("transparent", 64'(res_if.transparent),
							64'(want.transparent));
					if (res_if.last_out !== want.last)
						report_mismatch("last_out", 64'(res_if.last_out), 64'(want.last));
				end
			end
			if (pix_if.valid && pix_if.ready) begin
				pending_results.push_back(quantize_pixel(pix_if.pixel, pix_if.last_pixel));
				pixels_sent++;
			end
			if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready) ||
					(psel && penable)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles, %0d results outstanding",
					STALL_LIMIT, pending_results.size());
				$display("nearest_palette_quantizer_test: errors");
				$finish;
			end
		end
	end

	// Pixel sender. Entered and left at a falling edge; on return valid is still
	// high with the pixel just transferred, so the next call either replaces it
	// or drops valid for a gap, one assignment per edge either way.
	task automatic send_pixel(input logic [PIXEL_W-1:0] pixel, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			pix_if.valid = 1'b0;
			@(negedge clk);
		end
		pix_if.valid      = 1'b1;
		pix_if.pixel      = pixel;
		pix_if.last_pixel = last;
		do @(posedge clk); while (!pix_if.ready);
		@(negedge clk);
	endtask

	// Sender holds off until every owed result has arrived.
	task automatic wait_for_results();
		pix_if.valid = 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
	endtask

	// APB write then read-back of one palette register. Block must be idle.
	task automatic palette_write(input npq_reg_t sel, input logic [REG_W-1:0] value);
		logic [REG_W-1:0] readback;
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {sel, 3'b000};
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		palette_shadow[sel] = value;
		palette_writes++;
		@(negedge clk);
		penable = 1'b0;
		pwrite  = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		readback = prdata;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		if (readback !== value) report_mismatch($sformatf("read-back of %s", sel.name()),
			readback, value);
	endtask

	// Refill all four registers in the given pattern.
	task automatic load_palette(input palette_style_t style);
		logic [ENTRY_W-1:0] colours [3];
		logic [REG_W-1:0]   value;
		for (int c = 0; c < 3; c++) colours[c] = ENTRY_W'($urandom);
		wait_for_results();
		for (int r = 0; r < REG_COUNT; r++) begin
			for (int q = 0; q < 4; q++) begin
				case (style)
					PAL_RANDOM:    value[q*ENTRY_W +: ENTRY_W] = ENTRY_W'($urandom);
					// few distinct colours, so ties between indexes are common
					PAL_CLUSTERED: value[q*ENTRY_W +: ENTRY_W] = colours[$urandom_range(2)];
					PAL_SATURATED: value[q*ENTRY_W +: ENTRY_W] = '1;
					// channels 0..3 with random opaque bit: crowded near black
					default:       value[q*ENTRY_W +: ENTRY_W] = ENTRY_W'($urandom) & 16'h8C63;
				endcase
			end
			palette_write(npq_reg_t'(r), value);
		end
	endtask

	// Random pixel, weighted towards the interesting corners of the mapping.
	function automatic logic [PIXEL_W-1:0] random_pixel();
		logic [ENTRY_W-1:0] entry;
		int                 pick;
		int                 e;
		pick  = $urandom_range(99);
		e     = $urandom_range(MAX_ENTRIES - 1);
		entry = palette_shadow[e / 4][(e % 4) * ENTRY_W +: ENTRY_W];
		if (pick < 10) return PIXEL_W'($urandom) & 16'h7FFF;
		if (pick < 16) return SKIP_PIXEL;
		if (pick < 30) return entry | 16'h8000;
		if (pick < 45) return (entry ^ (16'h1 << $urandom_range(14))) | 16'h8000;
		return PIXEL_W'($urandom) | 16'h8000;
	endfunction

	// Palette straight out of reset is all zero: every opaque pixel maps to 0.
	task automatic test_reset_palette();
		send_pixel(16'h8000, 1'b0);
		send_pixel(16'hFFFF, 1'b0);
		send_pixel(16'h0000, 1'b1);
		send_pixel(16'hD5AA, 1'b1);
		wait_for_results();
	endtask

	// Each register through all-ones, checkerboard and zero, read back each time.
	task automatic test_register_access();
		for (int r = 0; r < REG_COUNT; r++) begin
			palette_write(npq_reg_t'(r), '1);
			palette_write(npq_reg_t'(r), 64'hA5A5_5A5A_F00F_0FF0);
			palette_write(npq_reg_t'(r), '0);
		end
	endtask

	// Hand-built palette: duplicates for ties, entries differing only in bit 15,
	// one entry nearer the odd pixel only when its top channel is ignored.
	task automatic test_directed_pixels();
		logic [PIXEL_W-1:0] probes [20] = '{
			16'h0000, 16'h7FFF, 16'h3A18, 16'h8000, 16'hFFFF,
			16'hBA18, 16'hBA19, 16'hBA10, 16'hFE18, 16'hC210,
			16'h8421, 16'h801F, 16'h83E0, 16'hFC00, 16'hAAAA,
			16'hD555, 16'hB9CE, 16'hFBDE, 16'h8C63, 16'hBA18
		};
		palette_write(REG_PAL_0_3,   {16'hFE18, 16'h3A14, 16'h7FFF, 16'h0000});
		palette_write(REG_PAL_4_7,   {16'h0000, 16'hFC00, 16'h83E0, 16'h801F});
		palette_write(REG_PAL_8_11,  {16'h6318, 16'h2108, 16'hC210, 16'h4210});
		palette_write(REG_PAL_12_15, {16'h7BDE, 16'h0421, 16'h5294, 16'h1CE7});
		for (int i = 0; i < 20; i++) send_pixel(probes[i], i[0]);
		// saturated palette: every entry identical, so index 0 throughout
		load_palette(PAL_SATURATED);
		send_pixel(16'h8000, 1'b1);
		send_pixel(16'hBA18, 1'b0);
		send_pixel(16'hFFFF, 1'b1);
		wait_for_results();
	endtask

	// Random stream under one idling profile, two palettes per phase. The
	// palette change in the middle also makes the sender wait for a full drain.
	task automatic test_random_stream(input int idle_pct, input int stall_pct,
			input palette_style_t first_style, input palette_style_t second_style,
			input int count);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		load_palette(first_style);
		for (int i = 0; i < count / 2; i++) send_pixel(random_pixel(), $urandom_range(7) == 0);
		load_palette(second_style);
		for (int i = 0; i < count - count / 2; i++)
			send_pixel(random_pixel(), $urandom_range(7) == 0);
		wait_for_results();
	endtask

	initial begin
		arst_n            = 1'b0;
		psel              = 1'b0;
		penable           = 1'b0;
		pwrite            = 1'b0;
		paddr             = '0;
		pwdata            = '0;
		pix_if.valid      = 1'b0;
		pix_if.pixel      = '0;
		pix_if.last_pixel = 1'b0;
		send_idle_pct     = 0;
		recv_stall_pct    = 0;
		pixels_sent       = 0;
		results_checked   = 0;
		palette_writes    = 0;
		mismatch_count    = 0;
		quiet_cycles      = 0;
		for (int r = 0; r < REG_COUNT; r++) palette_shadow[r] = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_palette();
		test_register_access();
		test_directed_pixels();
		test_random_stream(0,  0,  PAL_RANDOM,    PAL_CLUSTERED, 500);
		test_random_stream(61, 0,  PAL_DARK,      PAL_RANDOM,    500);
		test_random_stream(0,  61, PAL_CLUSTERED, PAL_SATURATED, 500);
		test_random_stream(24, 24, PAL_RANDOM,    PAL_DARK,      500);

		// stray results after the last one would show up in this window
		wait_for_results();
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("covered %0d pixels and %0d results, %0d palette writes with read-back",
			pixels_sent, results_checked, palette_writes);
		$display("idling: none, sender gaps, receiver stalls, both; %0d mismatches",
			mismatch_count);
		if (mismatch_count == 0) begin
			$display("nearest_palette_quantizer_test: clean");
		end else begin
			$display("nearest_palette_quantizer_test: errors");
		end
		$finish;
	end

endmodule

/* filelist.f */
hdl/npq_pkg.sv
hdl/npq_if.sv
hdl/npq_cfg.sv
hdl/npq_cell.sv
hdl/nearest_palette_quantizer.sv
test/nearest_palette_quantizer_test.sv
